/* rtl/sslt_pkg.sv */
// Shared types and constants for the sorted segment range table.
// Holds the controller state type, command and status codes, result field widths and parameter defaults.
// Depends on nothing; the top level and the checks module import it.
package sslt_pkg;

  // Parameter defaults for the top level.
  localparam int DEF_TABLE_DEPTH  = 16;
  localparam int DEF_CELL_BYTES   = 8;
  localparam int DEF_CARD_CELLS   = 256;
  localparam int DEF_HEADER_CELLS = 1;
  localparam int DEF_ADDR_BITS    = 32;

  // Fixed widths of the result fields.
  localparam int INDEX_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = 8;

  // Command codes carried on the input tuser.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_SCAN,
    S_DIV_WAIT,
    S_DONE
  } ctrl_state_t;

endpackage

/* rtl/sorted_segment_range_table.sv */
// Sorted segment range table: a command stream in, one result per command out.
// The input transaction carries the command on s_tuser (insert or lookup) and
// the address, upper bound and double-cell flag on s_tdata. Each command gives
// exactly one result transaction: an entry index and a status on m_tdata.
// Ranges live in one synchronous memory, kept sorted by lower bound.
// Insert walks down from the top of the table, moving one entry up per cycle
// until it finds the slot; an insert into an empty or full table moves nothing.
// Lookup scans the table from index 0 at one entry per cycle while two
// constant-modulus units work out cell, double-cell and card header alignment;
// a hit waits for them before its result is offered, and a miss is offered
// after the whole scan. A lookup outside the overall bounds, or on an empty
// table, skips the scan.
// One command is in work at a time; s_tready is high only when the block is
// idle, from the cycle after a result is loaded. A stalled receiver keeps its
// result in the output register; the next command is still accepted and
// worked, and its result waits until the register is free.
// Reset empties the table and clears the bounds; memory contents need no
// clearing because only entries below the entry count are ever used.
module sorted_segment_range_table
  import sslt_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int CELL_BYTES   = DEF_CELL_BYTES,
  parameter int CARD_CELLS   = DEF_CARD_CELLS,
  parameter int HEADER_CELLS = DEF_HEADER_CELLS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // address [ADDR_BITS-1:0], upper_bound, double_cell, then zero padding
  input  logic [((2*ADDR_BITS+8)/8)*8-1:0]     s_tdata,
  // command
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // entry_index [3:0], status [5:4], zero padding [7:6]
  output logic [OUT_TDATA_W-1:0]               m_tdata
);

  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W        = 2 * ADDR_BITS + 1;
  localparam int CARD_BYTES   = CARD_CELLS * CELL_BYTES;
  localparam int HEADER_BYTES = HEADER_CELLS * CELL_BYTES;
  localparam int DREM_W       = $clog2(2 * CELL_BYTES);
  localparam int KREM_W       = $clog2(CARD_BYTES);

  ctrl_state_t state, state_next;

  // Held command operands.
  logic [ADDR_BITS-1:0] op_addr;
  logic [ADDR_BITS-1:0] op_high;
  logic                 op_dbl;

  // Table bookkeeping.
  logic [CNT_W-1:0]     entry_count;
  logic [ADDR_BITS-1:0] lowest;
  logic [ADDR_BITS-1:0] highest;
  logic [IDX_W-1:0]     ins_k;
  logic [IDX_W-1:0]     chk_idx;
  logic [IDX_W-1:0]     hit_idx;
  logic                 hit_dbl;
  logic [INDEX_W-1:0]   res_index;
  logic [STATUS_W-1:0]  res_status;

  // Range memory: {double, high, low} per entry.
  logic [ENT_W-1:0]     mem [TABLE_DEPTH];
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;

  // Input fields.
  logic [ADDR_BITS-1:0] in_addr;
  logic [ADDR_BITS-1:0] in_high;
  logic                 in_dbl;
  logic                 accept;
  logic                 out_free;

  // Decode of the entry just read.
  logic [ADDR_BITS-1:0] rd_low;
  logic [ADDR_BITS-1:0] rd_high;
  logic                 rd_dbl;
  logic                 shift_more;
  logic                 scan_hit;
  logic                 scan_last;
  logic                 table_full;
  logic                 quick_miss;

  // Alignment units.
  logic                 div_start;
  logic                 div_busy;
  logic                 cell_busy;
  logic                 card_busy;
  logic [DREM_W-1:0]    pair_rem;
  logic [KREM_W-1:0]    card_rem;
  logic                 align_miss;

  assign in_addr  = s_tdata[ADDR_BITS-1:0];
  assign in_high  = s_tdata[2*ADDR_BITS-1:ADDR_BITS];
  assign in_dbl   = s_tdata[2*ADDR_BITS];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign rd_low  = rd_data[ADDR_BITS-1:0];
  assign rd_high = rd_data[2*ADDR_BITS-1:ADDR_BITS];
  assign rd_dbl  = rd_data[2*ADDR_BITS];

  // Conditions that steer the walk through the table.
  assign shift_more = (rd_low > op_addr);
  assign scan_hit   = (rd_low <= op_addr) && (op_addr < rd_high);
  assign scan_last  = ((CNT_W'(chk_idx) + CNT_W'(1)) == entry_count);
  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));
  assign quick_miss = (in_addr < lowest) || (in_addr >= highest) ||
                      (entry_count == '0);
  assign div_start  = accept && (s_tuser == CMD_LOOKUP);
  assign div_busy   = cell_busy || card_busy;

  // Misaligned cell, odd cell in a double-cell range, or a card header.
  // The remainder by two cells is zero or one cell for a cell aligned address.
  assign align_miss = ((pair_rem != '0) && (pair_rem != DREM_W'(CELL_BYTES))) ||
                      (hit_dbl && (pair_rem != '0)) ||
                      (card_rem < KREM_W'(HEADER_BYTES));

  sslt_cdiv #(
    .ADDR_BITS (ADDR_BITS),
    .DIVISOR   (2 * CELL_BYTES)
  ) u_cell_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_addr),
    .busy     (cell_busy),
    .rem      (pair_rem)
  );

  sslt_cdiv #(
    .ADDR_BITS (ADDR_BITS),
    .DIVISOR   (CARD_BYTES)
  ) u_card_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_addr),
    .busy     (card_busy),
    .rem      (card_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == CMD_INSERT) begin
            state_next = (table_full || entry_count == '0) ? S_DONE : S_INS;
          end else begin
            state_next = quick_miss ? S_DONE : S_SCAN;
          end
        end
      end
      S_INS: begin
        if (!shift_more) begin
          state_next = S_DONE;
        end else if (ins_k == IDX_W'(1)) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: state_next = S_DONE;
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_DIV_WAIT;
        end else if (scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    rd_addr = chk_idx + IDX_W'(1);
    wr_en   = 1'b0;
    wr_addr = ins_k;
    wr_data = {op_dbl, op_high, op_addr};
    unique case (state)
      S_IDLE: begin
        rd_addr = '0;
        wr_addr = '0;
        wr_data = {in_dbl, in_high, in_addr};
        if (accept && s_tuser == CMD_INSERT) begin
          rd_addr = IDX_W'(entry_count - CNT_W'(1));
          wr_en   = (entry_count == '0);
        end
      end
      S_INS: begin
        rd_addr = ins_k - IDX_W'(2);
        wr_en   = 1'b1;
        if (shift_more) begin
          wr_data = rd_data;
        end
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      S_SCAN, S_DIV_WAIT, S_DONE: begin
        rd_addr = chk_idx + IDX_W'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Range memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      lowest      <= '0;
      highest     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      // The result register loads when free and empties when taken.
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_addr <= in_addr;
            op_high <= in_high;
            op_dbl  <= in_dbl;
            chk_idx <= '0;
            ins_k   <= IDX_W'(entry_count);
            if (s_tuser == CMD_INSERT) begin
              if (table_full) begin
                res_index  <= '0;
                res_status <= ST_FULL;
              end else if (entry_count == '0) begin
                lowest      <= in_addr;
                highest     <= in_high;
                res_index   <= '0;
                res_status  <= ST_OK;
                entry_count <= entry_count + CNT_W'(1);
              end else begin
                if (in_addr < lowest) begin
                  lowest <= in_addr;
                end
                if (in_high > highest) begin
                  highest <= in_high;
                end
              end
            end else if (quick_miss) begin
              res_index  <= '0;
              res_status <= ST_MISS;
            end
          end
        end
        S_INS: begin
          if (shift_more) begin
            ins_k <= ins_k - IDX_W'(1);
          end else begin
            res_index   <= INDEX_W'(ins_k);
            res_status  <= ST_OK;
            entry_count <= entry_count + CNT_W'(1);
          end
        end
        S_INS_PUT: begin
          res_index   <= '0;
          res_status  <= ST_OK;
          entry_count <= entry_count + CNT_W'(1);
        end
        S_SCAN: begin
          if (scan_hit) begin
            hit_idx <= chk_idx;
            hit_dbl <= rd_dbl;
          end else if (scan_last) begin
            res_index  <= '0;
            res_status <= ST_MISS;
          end else begin
            chk_idx <= chk_idx + IDX_W'(1);
          end
        end
        S_DIV_WAIT: begin
          if (!div_busy) begin
            res_index  <= align_miss ? '0 : INDEX_W'(hit_idx);
            res_status <= align_miss ? ST_MISS : ST_OK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata <= {(OUT_TDATA_W - INDEX_W - STATUS_W)'(0), res_status, res_index};
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/sslt_cdiv.sv */
// Remainder of an address by a constant modulus, using weighted byte folding and
// a reciprocal multiplication in a three-stage pipeline.
// Depends on nothing outside this file.
module sslt_cdiv #(
  parameter int ADDR_BITS = 32,
  parameter int DIVISOR   = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ADDR_BITS-1:0]         dividend,
  output logic                         busy,
  output logic [$clog2(DIVISOR)-1:0]   rem
);

  localparam int REM_W   = $clog2(DIVISOR);
  localparam int NCHUNK  = (ADDR_BITS + 7) / 8;
  localparam int PAD_W   = NCHUNK * 8;
  localparam int SUM_MAX = NCHUNK * 255 * (DIVISOR - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int QUO_W   = $clog2(NCHUNK * 255 + 1);
  localparam int SHIFT   = SUM_W + REM_W;
  localparam int RCP_W   = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RCP_W;

  localparam logic [63:0] RCP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_FULL);

  typedef logic [NCHUNK-1:0][REM_W-1:0] weights_t;

  // Weight of each address byte: 256 to the power of its position, modulo the divisor.
  function automatic weights_t weight_table();
    weights_t tbl;
    int       w;
    int       i;
    w = 1;
    for (i = 0; i < NCHUNK; i++) begin
      tbl[i] = REM_W'(w % DIVISOR);
      w = (w * 256) % DIVISOR;
    end
    return tbl;
  endfunction

  localparam weights_t WEIGHTS = weight_table();

  logic [PAD_W-1:0]  padded;
  logic [SUM_W-1:0]  sum_comb;
  logic [SUM_W-1:0]  sum_reg;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo_reg;
  logic              stage1;
  logic              stage2;

  assign padded = PAD_W'(dividend);
  assign busy   = stage1 || stage2;

  // Fold the address bytes into a small sum with the same remainder.
  always_comb begin
    sum_comb = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      sum_comb = sum_comb + SUM_W'(padded[i*8 +: 8]) * SUM_W'(WEIGHTS[i]);
    end
  end

  // Quotient of the folded sum by reciprocal multiplication.
  assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP);

  // Fold, then quotient, then remainder; a new start restarts the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
    end else if (start) begin
      stage1  <= 1'b1;
      stage2  <= 1'b0;
      sum_reg <= sum_comb;
    end else begin
      stage1 <= 1'b0;
      stage2 <= stage1;
      if (stage1) begin
        quo_reg <= QUO_W'(prod >> SHIFT);
      end
      if (stage2) begin
        rem <= REM_W'(sum_reg - SUM_W'(quo_reg) * SUM_W'(DIVISOR));
      end
    end
  end

endmodule

/* rtl/sslt_checks.sv */
// Port-level checks for the sorted segment range table, bound to the top level.
// Watches the command and result channels only; uses sslt_pkg for codes.
// The bind statement at the end attaches it to every instance of the top level.
module sslt_checks
  import sslt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A held result stays offered until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[5:4] == ST_OK || m_tdata[5:4] == ST_MISS ||
                  m_tdata[5:4] == ST_FULL))
    else $error("undefined status code on result");

  // A failed command reports index zero.
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5:4] != ST_OK |-> m_tdata[3:0] == '0)
    else $error("non-zero index with a failing status");

  // One command at a time: ready drops after every accepted command.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command accepted while one is in work");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered straight after reset");

endmodule

bind sorted_segment_range_table sslt_checks u_sslt_checks (.*);
